// File: sv/closest_point_on_segment_defines.svh
// assertion macros shared by the closest point block
`ifndef CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CPOS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CPOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cpos_pkg.sv
// types, widths and helpers of the closest point on segment block
package cpos_pkg;

   localparam int COORD_W = 32;
   localparam int GIVEN_W = 31;
   localparam int AXES    = 3;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int RAD_W   = PROD_W;
   localparam int ROOT_W  = DIFF_W;
   localparam int LEN_W   = (ROOT_W > GIVEN_W) ? ROOT_W : GIVEN_W;
   localparam int NUM_W   = 2 * LEN_W + 1;
   localparam int SUM_W   = LEN_W + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [DIFF_W-1:0]         mag_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic [RAD_W-1:0]          rad_type;
   typedef logic [ROOT_W-1:0]         root_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic [NUM_W-1:0]          num_type;

   typedef enum logic [1:0] {
      CODE_INTERIOR = 2'd0,
      CODE_START    = 2'd1,
      CODE_END      = 2'd2,
      CODE_ZERO_LEN = 2'd3
   } case_code_type;

   typedef struct packed {
      logic               use_given_length;
      logic [GIVEN_W-1:0] segment_length;
      coord_type          point_x;
      coord_type          point_y;
      coord_type          point_z;
      coord_type          start_x;
      coord_type          start_y;
      coord_type          start_z;
      coord_type          end_x;
      coord_type          end_y;
      coord_type          end_z;
   } req_type;

   typedef struct packed {
      coord_type     nearest_x;
      coord_type     nearest_y;
      coord_type     nearest_z;
      case_code_type case_code;
   } rsp_type;

   // side data alongside the square root
   typedef struct packed {
      coord_type [AXES-1:0] s;
      coord_type [AXES-1:0] e;
      mag_type [AXES-1:0]   dmag;
      logic [AXES-1:0]      dneg;
      dot_type              dc;
      logic                 use_given;
      logic [GIVEN_W-1:0]   given_len;
   } side_a_type;

   // side data alongside the projection divider
   typedef struct packed {
      coord_type [AXES-1:0] s;
      coord_type [AXES-1:0] e;
      mag_type [AXES-1:0]   dmag;
      logic [AXES-1:0]      dneg;
      case_code_type        code;
      len_type              len;
   } side_b_type;

   // side data alongside the offset dividers
   typedef struct packed {
      coord_type [AXES-1:0] s;
      coord_type [AXES-1:0] e;
      logic [AXES-1:0]      dneg;
      case_code_type        code;
   } side_c_type;

   function automatic coord_type sat_coord(input logic signed [SUM_W-1:0] v);
      coord_type r;
      if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1) begin
         r = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: sv/cpos_sqrt.sv
// pipelined integer square root, one result bit per stage
module cpos_sqrt
   import cpos_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  rad_type  in_rad,
   output logic     out_valid,
   output root_type out_root
);

   logic [ROOT_W-1:0] vld_ff;
   rad_type           rem_ff  [ROOT_W];
   root_type          root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      rad_type        rem_prev;
      root_type       root_prev;
      logic           vld_prev;
      logic [RAD_W:0] trial;
      logic           take;
      rad_type        rem_in;
      root_type       root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = in_rad;
         assign root_prev = '0;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      assign trial = ((RAD_W+1)'(root_prev) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));
      assign take  = {1'b0, rem_prev} >= trial;
      assign rem_in  = take ? rem_prev - trial[RAD_W-1:0] : rem_prev;
      assign root_in = take ? (root_prev | (ROOT_W'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

// File: sv/cpos_div.sv
// pipelined restoring divider, one quotient bit per stage
module cpos_div
   import cpos_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  num_type in_num,
   input  len_type in_den,
   output logic    out_valid,
   output len_type out_quo
);

   logic [LEN_W-1:0] vld_ff;
   num_type          rem_ff [LEN_W];
   len_type          den_ff [LEN_W];
   len_type          quo_ff [LEN_W];

   for (genvar k = 0; k < LEN_W; k++) begin : g_stage
      localparam int B = LEN_W - 1 - k;
      num_type rem_prev;
      len_type den_prev;
      len_type quo_prev;
      logic    vld_prev;
      num_type shifted;
      logic    take;
      num_type rem_in;
      len_type quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      // quotient is known to fit, so the top bit starts the search
      assign shifted = NUM_W'(den_prev) << B;
      assign take    = rem_prev >= shifted;
      assign rem_in  = take ? rem_prev - shifted : rem_prev;
      assign quo_in  = take ? (quo_prev | (LEN_W'(1) << B)) : quo_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[LEN_W-1];
   assign out_quo   = quo_ff[LEN_W-1];

endmodule

// File: sv/closest_point_on_segment.sv
// top level: closest point on a 3d segment, fully pipelined
// usage:
//  - req_ channel takes one query item (point, start, end, optional length) per cycle
//    when req_valid is high and req_stall is low
//  - rsp_ channel returns the nearest point and a case code, one item per query, in order
//  - depth: an accepted item passes 106 registers on its way to rsp_valid:
//    three front stages (differences, products, dot sums), a 33 stage square root, two
//    stages for length select and clamp tests, a 33 stage divider for t, one product
//    stage, three 33 stage dividers in parallel for the offsets, and the output register
//  - one item per cycle when not stalled; the bit-per-stage root and dividers set the depth
//  - the whole pipe moves on one enable; an item leaving the pipe goes to the output
//    register, or to a one-entry skid register if the output is held by rsp_stall
//  - req_stall is the skid-full flag, straight from a flip-flop; while it is high the
//    pipe freezes and nothing is lost or repeated
//  - synchronous reset empties the pipe, output and skid; payload registers keep junk
//  - a zero length (degenerate segment or given length of zero) returns start, code 3
`include "closest_point_on_segment_defines.svh"

module closest_point_on_segment
   import cpos_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // pipe enable: frozen only while the skid holds an item
   logic en;
   logic skid_full_ff;
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // stage 1: differences d = e - s and c = p - s
   coord_type [AXES-1:0] p_in, s_in, e_in;
   diff_type [AXES-1:0]  d1_in, c1_in;
   logic                 vld1_ff;
   diff_type [AXES-1:0]  d1_ff, c1_ff;
   coord_type [AXES-1:0] s1_ff, e1_ff;
   logic                 use1_ff;
   logic [GIVEN_W-1:0]   given1_ff;

   assign p_in = {req_data.point_z, req_data.point_y, req_data.point_x};
   assign s_in = {req_data.start_z, req_data.start_y, req_data.start_x};
   assign e_in = {req_data.end_z, req_data.end_y, req_data.end_x};

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         d1_in[k] = DIFF_W'(e_in[k]) - DIFF_W'(s_in[k]);
         c1_in[k] = DIFF_W'(p_in[k]) - DIFF_W'(s_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff     <= d1_in;
         c1_ff     <= c1_in;
         s1_ff     <= s_in;
         e1_ff     <= e_in;
         use1_ff   <= req_data.use_given_length;
         given1_ff <= req_data.segment_length;
      end
   end

   // stage 2: per-axis products d*c and d*d, magnitudes of d
   prod_type [AXES-1:0]   dc2_in, dc2_ff;
   logic [AXES-1:0][PROD_W-1:0] sq2_in, sq2_ff;
   mag_type [AXES-1:0]    dmag2_in, dmag2_ff;
   logic [AXES-1:0]       dneg2_ff;
   logic                  vld2_ff;
   coord_type [AXES-1:0]  s2_ff, e2_ff;
   logic                  use2_ff;
   logic [GIVEN_W-1:0]    given2_ff;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         dc2_in[k]   = PROD_W'($signed(d1_ff[k]) * $signed(c1_ff[k]));
         sq2_in[k]   = PROD_W'($signed(d1_ff[k]) * $signed(d1_ff[k]));
         dmag2_in[k] = d1_ff[k][DIFF_W-1] ? mag_type'(-d1_ff[k]) : mag_type'(d1_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc2_ff   <= dc2_in;
         sq2_ff   <= sq2_in;
         dmag2_ff <= dmag2_in;
         for (int k = 0; k < AXES; k++) begin
            dneg2_ff[k] <= d1_ff[k][DIFF_W-1];
         end
         s2_ff     <= s1_ff;
         e2_ff     <= e1_ff;
         use2_ff   <= use1_ff;
         given2_ff <= given1_ff;
      end
   end

   // stage 3: dot product sum and squared length
   dot_type    dc3_in;
   rad_type    ss3_in;
   rad_type    ss3_ff;
   side_a_type side3_ff;
   logic       vld3_ff;

   always_comb begin
      dc3_in = '0;
      ss3_in = '0;
      for (int k = 0; k < AXES; k++) begin
         dc3_in = dc3_in + DOT_W'(dc2_ff[k]);
         ss3_in = ss3_in + RAD_W'(sq2_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss3_ff             <= ss3_in;
         side3_ff.s         <= s2_ff;
         side3_ff.e         <= e2_ff;
         side3_ff.dmag      <= dmag2_ff;
         side3_ff.dneg      <= dneg2_ff;
         side3_ff.dc        <= dc3_in;
         side3_ff.use_given <= use2_ff;
         side3_ff.given_len <= given2_ff;
      end
   end

   // square root of the squared length, side data in a matching delay line
   logic       root_vld;
   root_type   root;
   side_a_type sidea_dly_ff [ROOT_W];

   cpos_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld3_ff),
      .in_rad    (ss3_ff),
      .out_valid (root_vld),
      .out_root  (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sidea_dly_ff[0] <= side3_ff;
         for (int i = 1; i < ROOT_W; i++) begin
            sidea_dly_ff[i] <= sidea_dly_ff[i-1];
         end
      end
   end

   // stage 4: pick the length and form len*(len+1) for the far clamp test
   side_a_type       sidea_out;
   len_type          len4_in;
   logic [LEN_W:0]   lenp1_in;
   num_type          lenprod4_in;
   len_type          len4_ff;
   num_type          lenprod4_ff;
   side_a_type       side4_ff;
   logic             vld4_ff;

   assign sidea_out   = sidea_dly_ff[ROOT_W-1];
   assign len4_in     = sidea_out.use_given ? LEN_W'(sidea_out.given_len) : LEN_W'(root);
   assign lenp1_in    = {1'b0, len4_in} + 1'b1;
   assign lenprod4_in = NUM_W'(len4_in * lenp1_in);

   always_ff @(posedge clock) begin
      if (en) begin
         len4_ff     <= len4_in;
         lenprod4_ff <= lenprod4_in;
         side4_ff    <= sidea_out;
      end
   end

   // stage 5: case decision; t = dc / len is only used for interior items
   case_code_type code5_in;
   num_type       num5_ff;
   side_b_type    side5_ff;
   logic          vld5_ff;

   always_comb begin
      if (len4_ff == '0) begin
         code5_in = CODE_ZERO_LEN;
      end else if (side4_ff.dc[DOT_W-1]) begin
         code5_in = CODE_START;
      end else if (NUM_W'($unsigned(side4_ff.dc)) >= lenprod4_ff) begin
         code5_in = CODE_END;
      end else begin
         code5_in = CODE_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num5_ff       <= NUM_W'($unsigned(side4_ff.dc));
         side5_ff.s    <= side4_ff.s;
         side5_ff.e    <= side4_ff.e;
         side5_ff.dmag <= side4_ff.dmag;
         side5_ff.dneg <= side4_ff.dneg;
         side5_ff.code <= code5_in;
         side5_ff.len  <= len4_ff;
      end
   end

   // projection divider t = dc / len
   logic       t_vld;
   len_type    t_quo;
   side_b_type sideb_dly_ff [LEN_W];

   cpos_div u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld5_ff),
      .in_num    (num5_ff),
      .in_den    (side5_ff.len),
      .out_valid (t_vld),
      .out_quo   (t_quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sideb_dly_ff[0] <= side5_ff;
         for (int i = 1; i < LEN_W; i++) begin
            sideb_dly_ff[i] <= sideb_dly_ff[i-1];
         end
      end
   end

   // stage 6: offset numerators |d| * t
   side_b_type          sideb_out;
   num_type [AXES-1:0]  num6_ff;
   len_type             len6_ff;
   side_c_type          side6_ff;
   logic                vld6_ff;

   assign sideb_out = sideb_dly_ff[LEN_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < AXES; k++) begin
            num6_ff[k] <= NUM_W'(sideb_out.dmag[k] * t_quo);
         end
         len6_ff       <= sideb_out.len;
         side6_ff.s    <= sideb_out.s;
         side6_ff.e    <= sideb_out.e;
         side6_ff.dneg <= sideb_out.dneg;
         side6_ff.code <= sideb_out.code;
      end
   end

   // offset dividers, one lane per axis
   logic [AXES-1:0]    q_vld;
   len_type [AXES-1:0] q_quo;
   side_c_type         sidec_dly_ff [LEN_W];

   for (genvar k = 0; k < AXES; k++) begin : g_lane
      cpos_div u_div_q (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld6_ff),
         .in_num    (num6_ff[k]),
         .in_den    (len6_ff),
         .out_valid (q_vld[k]),
         .out_quo   (q_quo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidec_dly_ff[0] <= side6_ff;
         for (int i = 1; i < LEN_W; i++) begin
            sidec_dly_ff[i] <= sidec_dly_ff[i-1];
         end
      end
   end

   // valid bits of stages 1 to 6
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= root_vld;
         vld5_ff <= vld4_ff;
         vld6_ff <= t_vld;
      end
   end

   // final: s + signed offset, saturated, then pick by case code
   side_c_type                     sidec_out;
   logic signed [SUM_W-1:0]        off_in [AXES];
   logic signed [SUM_W-1:0]        sum_in [AXES];
   coord_type [AXES-1:0]           sat_in;
   coord_type [AXES-1:0]           pick_in;
   rsp_type                        res_in;
   logic                           vld_last;

   assign sidec_out = sidec_dly_ff[LEN_W-1];
   assign vld_last  = q_vld[0];

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         off_in[k] = sidec_out.dneg[k] ? -$signed(SUM_W'(q_quo[k])) : $signed(SUM_W'(q_quo[k]));
         sum_in[k] = SUM_W'(sidec_out.s[k]) + off_in[k];
         sat_in[k] = sat_coord(sum_in[k]);
      end
      case (sidec_out.code)
         CODE_INTERIOR: pick_in = sat_in;
         CODE_END:      pick_in = sidec_out.e;
         CODE_START:    pick_in = sidec_out.s;
         CODE_ZERO_LEN: pick_in = sidec_out.s;
         default:       pick_in = sidec_out.s;
      endcase
      res_in.nearest_x = pick_in[0];
      res_in.nearest_y = pick_in[1];
      res_in.nearest_z = pick_in[2];
      res_in.case_code = sidec_out.code;
   end

   // output register and skid
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    take;
   logic    leave;

   assign take  = out_valid_ff && !rsp_stall;
   assign leave = en && vld_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (leave) begin
         if (out_valid_ff && !take) begin
            skid_full_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (leave) begin
         if (!out_valid_ff || take) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `CPOS_ASSERT_NOW(a_skid_has_out, skid_full_ff, out_valid_ff, "skid item without output item")
   `CPOS_ASSERT_NEXT(a_pipe_holds, vld_last && !en, vld_last, "pipe item lost while frozen")
   `CPOS_ASSERT_NEXT(a_skid_catches, leave && out_valid_ff && rsp_stall, skid_full_ff, "item not caught by skid")
   `CPOS_ASSERT_NOW(a_lanes_agree, q_vld != '0, &q_vld, "offset lanes out of step")

endmodule

// File: verif/closest_point_on_segment_tb.sv
// self-checking testbench for the closest point on segment block
module closest_point_on_segment_tb
   import cpos_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   closest_point_on_segment u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // queries waiting to be offered, and nearest points waiting to come back
   req_type query_queue[$];
   rsp_type nearest_queue[$];

   // traffic shaping and bench counters; the shaping knobs are set by the stimulus process
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_cycles;
   bit  hold_req;
   bit  send_pause;
   int  mismatch_count;
   int  cycle_count;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // exact integer model of the projection and clamp
   function automatic rsp_type nearest_point(input req_type q);
      rsp_type r;
      longint p[3], s[3], e[3], d[3], c[3];
      logic signed [127:0] dot, sq, lim, num, off, sum;
      logic [127:0] len, root, cand, t;
      for (int k = 0; k < 3; k++) begin
         p[k] = 0;
      end
      p[0] = q.point_x; p[1] = q.point_y; p[2] = q.point_z;
      s[0] = q.start_x; s[1] = q.start_y; s[2] = q.start_z;
      e[0] = q.end_x;   e[1] = q.end_y;   e[2] = q.end_z;
      dot = 0;
      sq  = 0;
      for (int k = 0; k < 3; k++) begin
         d[k] = e[k] - s[k];
         c[k] = p[k] - s[k];
         dot += 128'(d[k]) * 128'(c[k]);
         sq  += 128'(d[k]) * 128'(d[k]);
      end
      if (q.use_given_length) begin
         len = 128'(q.segment_length);
      end else begin
         // bitwise integer square root
         root = 0;
         for (int b = 63; b >= 0; b--) begin
            cand = root | (128'(1) << b);
            if (cand * cand <= sq) root = cand;
         end
         len = root;
      end
      lim = len * (len + 1);
      if (len == 0) begin
         r.case_code = CODE_ZERO_LEN;
         r.nearest_x = s[0]; r.nearest_y = s[1]; r.nearest_z = s[2];
      end else if (dot < 0) begin
         r.case_code = CODE_START;
         r.nearest_x = s[0]; r.nearest_y = s[1]; r.nearest_z = s[2];
      end else if (dot >= lim) begin
         r.case_code = CODE_END;
         r.nearest_x = e[0]; r.nearest_y = e[1]; r.nearest_z = e[2];
      end else begin
         r.case_code = CODE_INTERIOR;
         t = dot / len;
         for (int k = 0; k < 3; k++) begin
            // magnitude divided, sign restored: rounds toward zero
            num = (d[k] < 0) ? -128'(d[k]) : 128'(d[k]);
            off = (num * t) / len;
            if (d[k] < 0) off = -off;
            sum = 128'(s[k]) + off;
            if (sum > 128'sh7fffffff) sum = 128'sh7fffffff;
            else if (sum < -128'sh80000000) sum = -128'sh80000000;
            case (k)
               0: r.nearest_x = sum[31:0];
               1: r.nearest_y = sum[31:0];
               default: r.nearest_z = sum[31:0];
            endcase
         end
      end
      return r;
   endfunction

   function automatic coord_type rand_coord(input int mode);
      coord_type v;
      case (mode)
         0: v = $urandom;
         1: v = $urandom_range(0, 2000) - 1000;
         2: v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: v = $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      endcase
      return v;
   endfunction

   // random query, mostly well-formed segments with points around them
   function automatic req_type rand_query();
      req_type q;
      int mode;
      mode = $urandom_range(0, 9);
      mode = (mode < 2) ? 0 : (mode < 3) ? 2 : (mode < 5) ? 1 : 3;
      q.use_given_length = ($urandom_range(0, 3) == 0);
      q.segment_length   = ($urandom_range(0, 1) != 0) ? 31'($urandom)
                                                       : 31'($urandom_range(0, 300000));
      if ($urandom_range(0, 19) == 0) q.segment_length = '0;
      q.start_x = rand_coord(mode); q.start_y = rand_coord(mode);
      q.start_z = rand_coord(mode);
      q.end_x = rand_coord(mode); q.end_y = rand_coord(mode); q.end_z = rand_coord(mode);
      if ($urandom_range(0, 24) == 0) begin
         q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
      end
      q.point_x = rand_coord(mode); q.point_y = rand_coord(mode);
      q.point_z = rand_coord(mode);
      return q;
   endfunction

   function automatic req_type make_query(input bit given, input logic [30:0] glen,
      input coord_type px, py, pz, sx, sy, sz, ex, ey, ez);
      req_type q;
      q.use_given_length = given; q.segment_length = glen;
      q.point_x = px; q.point_y = py; q.point_z = pz;
      q.start_x = sx; q.start_y = sy; q.start_z = sz;
      q.end_x = ex; q.end_y = ey; q.end_z = ez;
      return q;
   endfunction

   // driver: offer the head of the queue; a held item stays put
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) nearest_queue.push_back(nearest_point(req_data));
         if (query_queue.size() != 0 && !send_pause &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= query_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_req && hold_cycles == 0) begin
         hold_cycles <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 1) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         hold_cycles <= 0;
         rsp_stall   <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: compare each returned item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (nearest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item %p", rsp_data);
         end else begin
            want = nearest_queue.pop_front();
            if (rsp_data.nearest_x !== want.nearest_x ||
                rsp_data.nearest_y !== want.nearest_y ||
                rsp_data.nearest_z !== want.nearest_z ||
                rsp_data.case_code !== want.case_code) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("closest_point_on_segment test failed");
         $finish;
      end
   end

   task automatic drain();
      while (query_queue.size() != 0 || req_valid || nearest_queue.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      coord_type mx, mn;
      mx = 32'sh7fffffff;
      mn = 32'sh80000000;
      reset = 1'b1;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 37;
      recv_idle_pct = 48;
      hold_req = 1'b0;
      send_pause = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: interior, both clamps, zero length, given lengths, extremes
      query_queue.push_back(make_query(0, 0, 5<<16, 3<<16, 0, 0, 0, 0, 10<<16, 0, 0));
      query_queue.push_back(make_query(0, 0, -(5<<16), 1, 2, 0, 0, 0, 10<<16, 0, 0));
      query_queue.push_back(make_query(0, 0, 20<<16, 0, 0, 0, 0, 0, 10<<16, 0, 0));
      query_queue.push_back(make_query(0, 0, 7, 8, 9, 4, 4, 4, 4, 4, 4));
      query_queue.push_back(make_query(1, 0, 7, 8, 9, 1, 2, 3, 50, 60, 70));
      query_queue.push_back(make_query(1, 31'h7fffffff, 1, 1, 1, 0, 0, 0, 3, 4, 0));
      query_queue.push_back(make_query(1, 3, 300, 400, 0, 0, 0, 0, 3, 4, 0));
      query_queue.push_back(make_query(0, 0, 100, 0, 0, 0, 0, 0, 1, 0, 0));
      query_queue.push_back(make_query(0, 0, mx, mx, mx, mn, mn, mn, mx, mx, mx));
      query_queue.push_back(make_query(0, 0, mn, mn, mn, mx, mx, mx, mn, mn, mn));
      query_queue.push_back(make_query(0, 0, 0, 0, 0, mn, mn, mn, mx, mx, mx));
      query_queue.push_back(make_query(0, 0, 0, 0, 0, mx, mn, mx, mn, mx, mn));
      query_queue.push_back(make_query(1, 31'h7fffffff, mx, mx, mx, mn, mn, mn, mx, mx, mx));
      query_queue.push_back(make_query(1, 1, mx, 0, 0, 0, 0, 0, mx, 0, 0));
      query_queue.push_back(make_query(1, 2, 0, mx, 0, 0, mn, 0, 0, mx, 0));
      query_queue.push_back(make_query(0, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      query_queue.push_back(make_query(0, 0, 10, 0, 0, 0, 0, 0, 10, 0, 0));
      query_queue.push_back(make_query(1, 31'h2aaaaaaa, 32'h55555555, 32'haaaaaaaa,
         1, 32'haaaaaaaa, 32'h55555555, -2, 32'h55555555, 32'haaaaaaaa, 7));
      drain();

      // long receiver hold-off with the sender still pushing
      for (int i = 0; i < 300; i++) query_queue.push_back(rand_query());
      send_idle_pct = 0;
      hold_req = 1'b1;
      @(posedge clock);
      hold_req = 1'b0;
      drain();

      // idle gaps on both sides, then wait until everything has come back
      for (int i = 0; i < 350; i++) query_queue.push_back(rand_query());
      send_idle_pct = 37;
      recv_idle_pct = 48;
      drain();

      for (int i = 0; i < 350; i++) query_queue.push_back(rand_query());
      send_idle_pct = 48;
      recv_idle_pct = 37;
      drain();

      for (int i = 0; i < 350; i++) query_queue.push_back(rand_query());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();

      // let any stray item surface past the pipe depth
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("closest_point_on_segment test passed");
      end else begin
         $display("closest_point_on_segment test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/cpos_pkg.sv
sv/cpos_sqrt.sv
sv/cpos_div.sv
sv/closest_point_on_segment.sv
verif/closest_point_on_segment_tb.sv
